/* hw/rtl/spfe_pkg.sv */
// Shared types, constants and helper functions for the sequence-pair
// floorplan evaluator. No dependencies; the top level imports it.
package spfe_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int DIM_BITS   = 16;

  localparam int AW      = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int RANK_W  = 6;
  localparam int COORD_W = 22;
  localparam int AREA_W  = 44;
  localparam int CFG_W   = 7;
  localparam int SUM_W   = ((COORD_W > DIM_BITS) ? COORD_W : DIM_BITS) + 1;

  // stream payload widths (byte padded)
  localparam int IN_BITS  = 59;
  localparam int IN_W     = 64;
  localparam int OUT_BITS = 138;
  localparam int OUT_W    = 144;
  localparam int OUT_PAD  = OUT_W - OUT_BITS;

  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_SWAP_POS = 3'd1;
  localparam logic [2:0] OP_SWAP_NEG = 3'd2;
  localparam logic [2:0] OP_SWAP_ALL = 3'd3;
  localparam logic [2:0] OP_ROTATE   = 3'd4;
  localparam logic [2:0] OP_EVAL     = 3'd5;

  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [DIM_BITS-1:0] dim_t;
  typedef logic [COORD_W-1:0]  coord_t;

  typedef struct packed {
    rank_t pos;
    rank_t neg;
    dim_t  w;
    dim_t  h;
  } blk_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } place_t;

  function automatic dim_t to_dim(logic [15:0] v);
    logic [DIM_BITS+15:0] t;
    t = {{DIM_BITS{1'b0}}, v};
    return t[DIM_BITS-1:0];
  endfunction

  function automatic logic idx_ok(logic [5:0] v);
    return CFG_W'(v) < CFG_W'(MAX_BLOCKS);
  endfunction

  // far edge of a block, saturated to the coordinate range
  function automatic coord_t sat_end(coord_t c, dim_t d);
    logic [SUM_W-1:0] s;
    s = SUM_W'(c) + SUM_W'(d);
    return (s > SUM_W'({COORD_W{1'b1}})) ? {COORD_W{1'b1}} : s[COORD_W-1:0];
  endfunction

endpackage

/* hw/rtl/sequence_pair_floorplan_evaluator.sv */
// Sequence-pair floorplan evaluator, top level: control sequencer and the
// block, placement and order memories. Depends on spfe_pkg and spfe_ram.
//
// Loads, rotates and swaps edit a block table held in RAM; a swap or an
// evaluate then packs the first n = min(block_count, MAX_BLOCKS) blocks and
// streams one result transaction per block, in block order, tlast on the
// final one. A packing runs through the single read port of the block
// table: a sort pass ranks every block by negative rank, a placement pass
// takes the blocks in that order and scans all n blocks for each, then a
// dimension scan and the area multiply; the results then go out one at a
// time as the sink takes them. One input transaction is worked on at a
// time; s_axis_tready is high only between operations. block_count may be
// written at any time the block is idle; the configuration channel is
// always ready. Table entries have no reset value and must be loaded
// before they take part in a packing.
module sequence_pair_floorplan_evaluator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config: block_count
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [spfe_pkg::CFG_W-1:0] cfg_data_i,
  // tdata, from bit 0: operation[3], first_index[6], second_index[6],
  // pos_rank[6], neg_rank[6], block_width[16], block_height[16], zero pad
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [spfe_pkg::IN_W-1:0] s_axis_tdata,
  // tdata, from bit 0: block_index[6], x_position[22], y_position[22],
  // chip_width[22], chip_height[22], chip_area[44], zero pad
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [spfe_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);
  import spfe_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_ROT_RD  = 5'd1;
  localparam logic [4:0] ST_ROT_WR  = 5'd2;
  localparam logic [4:0] ST_SW_RA   = 5'd3;
  localparam logic [4:0] ST_SW_RB   = 5'd4;
  localparam logic [4:0] ST_SW_W1   = 5'd5;
  localparam logic [4:0] ST_SW_W2   = 5'd6;
  localparam logic [4:0] ST_PACK    = 5'd7;
  localparam logic [4:0] ST_SORT_J  = 5'd8;
  localparam logic [4:0] ST_SORT_JD = 5'd9;
  localparam logic [4:0] ST_SORT_SC = 5'd10;
  localparam logic [4:0] ST_PL_ORD  = 5'd11;
  localparam logic [4:0] ST_PL_J    = 5'd12;
  localparam logic [4:0] ST_PL_JD   = 5'd13;
  localparam logic [4:0] ST_PL_SC   = 5'd14;
  localparam logic [4:0] ST_DIM_SC  = 5'd15;
  localparam logic [4:0] ST_AREA    = 5'd16;
  localparam logic [4:0] ST_EM_RD   = 5'd17;
  localparam logic [4:0] ST_EM_LD   = 5'd18;
  localparam logic [4:0] ST_EM_WT   = 5'd19;

  // input fields
  logic [2:0]  in_op;
  logic [5:0]  in_a, in_b, in_pos, in_neg;
  logic [15:0] in_w, in_h;
  assign in_op  = s_axis_tdata[2:0];
  assign in_a   = s_axis_tdata[8:3];
  assign in_b   = s_axis_tdata[14:9];
  assign in_pos = s_axis_tdata[20:15];
  assign in_neg = s_axis_tdata[26:21];
  assign in_w   = s_axis_tdata[42:27];
  assign in_h   = s_axis_tdata[58:43];

  logic [4:0]       state_q, state_d;
  logic [CFG_W-1:0] bcnt_q;
  logic [CNT_W-1:0] n;
  logic [2:0]       op_q, op_d;
  logic [AW-1:0]    a_q, a_d, b_q, b_d;
  logic [CNT_W-1:0] outer_q, outer_d, scan_q, scan_d, outer_nx;
  logic             rv_q, rv_d;
  logic [AW-1:0]    ri_q, ri_d, k_q, k_d, j_q, j_d;
  rank_t            jpos_q, jpos_d, jneg_q, jneg_d;
  coord_t           xb_q, xb_d, yb_q, yb_d, cw_q, cw_d, ch_q, ch_d;
  logic [AREA_W-1:0] area_q, area_d;
  blk_t             ea_q, ea_d, eb_q, eb_d;
  logic [AW-1:0]    oidx_q, oidx_d;
  coord_t           ox_q, ox_d, oy_q, oy_d;
  logic             olast_q, olast_d, mv_q, mv_d;

  // memory ports
  logic          tw_en, pw_en, ow_en;
  logic [AW-1:0] tw_addr, tr_addr, pw_addr, pr_addr, ow_addr, ow_data, or_addr;
  blk_t          tw_data, tr_data;
  place_t        pw_data, pr_data;
  logic [AW-1:0] or_data;

  logic in_acc, out_acc, scan_go, scan_done, outer_last;
  coord_t e_x, e_y;

  assign n = (bcnt_q > CFG_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(bcnt_q);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign outer_nx   = outer_q + CNT_W'(1);
  assign outer_last = (outer_nx == n);
  assign scan_go    = (scan_q < n);
  assign scan_done  = !scan_go && !rv_q;
  assign e_x = sat_end(pr_data.x, tr_data.w);
  assign e_y = sat_end(pr_data.y, tr_data.h);

  spfe_ram #(.WIDTH($bits(blk_t)), .DEPTH(MAX_BLOCKS)) u_blk_ram (
    .clk_i, .we_i(tw_en), .waddr_i(tw_addr), .wdata_i(tw_data),
    .raddr_i(tr_addr), .rdata_o(tr_data)
  );

  spfe_ram #(.WIDTH($bits(place_t)), .DEPTH(MAX_BLOCKS)) u_place_ram (
    .clk_i, .we_i(pw_en), .waddr_i(pw_addr), .wdata_i(pw_data),
    .raddr_i(pr_addr), .rdata_o(pr_data)
  );

  // placement order: slot k holds the block with the k-th lowest negative rank
  spfe_ram #(.WIDTH(AW), .DEPTH(MAX_BLOCKS)) u_order_ram (
    .clk_i, .we_i(ow_en), .waddr_i(ow_addr), .wdata_i(ow_data),
    .raddr_i(or_addr), .rdata_o(or_data)
  );

  always_comb begin
    state_d = state_q;
    op_d = op_q;  a_d = a_q;  b_d = b_q;
    outer_d = outer_q;  scan_d = scan_q;  rv_d = 1'b0;  ri_d = ri_q;
    k_d = k_q;  j_d = j_q;  jpos_d = jpos_q;  jneg_d = jneg_q;
    xb_d = xb_q;  yb_d = yb_q;  cw_d = cw_q;  ch_d = ch_q;  area_d = area_q;
    ea_d = ea_q;  eb_d = eb_q;
    oidx_d = oidx_q;  ox_d = ox_q;  oy_d = oy_q;  olast_d = olast_q;
    mv_d = mv_q;
    tw_en = 1'b0;  tw_addr = a_q;  tw_data = ea_q;  tr_addr = a_q;
    pw_en = 1'b0;  pw_addr = j_q;  pw_data = '{x: xb_q, y: yb_q};
    pr_addr = scan_q[AW-1:0];
    ow_en = 1'b0;  ow_addr = k_q;  ow_data = j_q;  or_addr = outer_q[AW-1:0];

    // shared scan issue: one address per cycle, read data in the next cycle
    if ((state_q == ST_SORT_SC) || (state_q == ST_PL_SC) || (state_q == ST_DIM_SC)) begin
      tr_addr = scan_q[AW-1:0];
      if (scan_go) begin
        scan_d = scan_q + CNT_W'(1);
        rv_d   = 1'b1;
        ri_d   = scan_q[AW-1:0];
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d = in_op;
          a_d  = in_a[AW-1:0];
          b_d  = in_b[AW-1:0];
          case (in_op)
            OP_LOAD: begin
              tw_en   = idx_ok(in_a);
              tw_addr = in_a[AW-1:0];
              tw_data = '{pos: in_pos, neg: in_neg, w: to_dim(in_w), h: to_dim(in_h)};
            end
            OP_SWAP_POS, OP_SWAP_NEG, OP_SWAP_ALL: begin
              state_d = (idx_ok(in_a) && idx_ok(in_b)) ? ST_SW_RA : ST_PACK;
            end
            OP_ROTATE: begin
              if (idx_ok(in_a)) begin
                state_d = ST_ROT_RD;
              end
            end
            OP_EVAL: begin
              state_d = ST_PACK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROT_RD: begin
        state_d = ST_ROT_WR;
      end
      ST_ROT_WR: begin
        tw_en   = 1'b1;
        tw_data = '{pos: tr_data.pos, neg: tr_data.neg, w: tr_data.h, h: tr_data.w};
        state_d = ST_IDLE;
      end
      ST_SW_RA: begin
        state_d = ST_SW_RB;
      end
      ST_SW_RB: begin
        tr_addr = b_q;
        ea_d    = tr_data;
        state_d = ST_SW_W1;
      end
      ST_SW_W1: begin
        eb_d    = tr_data;
        tw_en   = 1'b1;
        tw_data = '{pos: (op_q != OP_SWAP_NEG) ? tr_data.pos : ea_q.pos,
                    neg: (op_q != OP_SWAP_POS) ? tr_data.neg : ea_q.neg,
                    w: ea_q.w, h: ea_q.h};
        state_d = ST_SW_W2;
      end
      ST_SW_W2: begin
        tw_en   = 1'b1;
        tw_addr = b_q;
        tw_data = '{pos: (op_q != OP_SWAP_NEG) ? ea_q.pos : eb_q.pos,
                    neg: (op_q != OP_SWAP_POS) ? ea_q.neg : eb_q.neg,
                    w: eb_q.w, h: eb_q.h};
        state_d = ST_PACK;
      end
      ST_PACK: begin
        outer_d = '0;
        state_d = (n == '0) ? ST_IDLE : ST_SORT_J;
      end
      // sort: k = number of blocks ahead of j in placement order
      ST_SORT_J: begin
        tr_addr = outer_q[AW-1:0];
        state_d = ST_SORT_JD;
      end
      ST_SORT_JD: begin
        jneg_d  = tr_data.neg;
        j_d     = outer_q[AW-1:0];
        k_d     = '0;
        scan_d  = '0;
        state_d = ST_SORT_SC;
      end
      ST_SORT_SC: begin
        if (rv_q && ((tr_data.neg < jneg_q) ||
                     ((tr_data.neg == jneg_q) && (ri_q < j_q)))) begin
          k_d = k_q + AW'(1);
        end
        if (scan_done) begin
          ow_en   = 1'b1;
          outer_d = outer_last ? '0 : outer_nx;
          state_d = outer_last ? ST_PL_ORD : ST_SORT_J;
        end
      end
      // placement: longest path over blocks already placed
      ST_PL_ORD: begin
        state_d = ST_PL_J;
      end
      ST_PL_J: begin
        tr_addr = or_data;
        j_d     = or_data;
        state_d = ST_PL_JD;
      end
      ST_PL_JD: begin
        jpos_d  = tr_data.pos;
        jneg_d  = tr_data.neg;
        xb_d    = '0;
        yb_d    = '0;
        scan_d  = '0;
        state_d = ST_PL_SC;
      end
      ST_PL_SC: begin
        if (rv_q && (tr_data.neg < jneg_q)) begin
          if (tr_data.pos < jpos_q) begin
            if (e_x > xb_q) xb_d = e_x;
          end else if (tr_data.pos > jpos_q) begin
            if (e_y > yb_q) yb_d = e_y;
          end
        end
        if (scan_done) begin
          pw_en = 1'b1;
          if (outer_last) begin
            scan_d  = '0;
            cw_d    = '0;
            ch_d    = '0;
            state_d = ST_DIM_SC;
          end else begin
            outer_d = outer_nx;
            state_d = ST_PL_ORD;
          end
        end
      end
      ST_DIM_SC: begin
        if (rv_q) begin
          if (e_x > cw_q) cw_d = e_x;
          if (e_y > ch_q) ch_d = e_y;
        end
        if (scan_done) begin
          state_d = ST_AREA;
        end
      end
      ST_AREA: begin
        area_d  = AREA_W'(cw_q) * AREA_W'(ch_q);
        outer_d = '0;
        state_d = ST_EM_RD;
      end
      ST_EM_RD: begin
        pr_addr = outer_q[AW-1:0];
        state_d = ST_EM_LD;
      end
      ST_EM_LD: begin
        oidx_d  = outer_q[AW-1:0];
        ox_d    = pr_data.x;
        oy_d    = pr_data.y;
        olast_d = outer_last;
        mv_d    = 1'b1;
        state_d = ST_EM_WT;
      end
      ST_EM_WT: begin
        if (out_acc) begin
          mv_d    = 1'b0;
          outer_d = outer_nx;
          state_d = olast_q ? ST_IDLE : ST_EM_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bcnt_q  <= CFG_W'(MAX_BLOCKS);
      mv_q    <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mv_q    <= mv_d;
      rv_q    <= rv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bcnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  a_q <= a_d;  b_q <= b_d;
    outer_q <= outer_d;  scan_q <= scan_d;  ri_q <= ri_d;
    k_q <= k_d;  j_q <= j_d;  jpos_q <= jpos_d;  jneg_q <= jneg_d;
    xb_q <= xb_d;  yb_q <= yb_d;  cw_q <= cw_d;  ch_q <= ch_d;  area_q <= area_d;
    ea_q <= ea_d;  eb_q <= eb_d;
    oidx_q <= oidx_d;  ox_q <= ox_d;  oy_q <= oy_d;  olast_q <= olast_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, area_q, ch_q, cw_q, oy_q, ox_q, 6'(oidx_q)};

  // no result may be pending once a new transaction can be taken
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("result pending while idle");

  // the final result of a packing returns the block to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after final result");

  // results are shown only from the emit wait state
  a_valid_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (state_q == ST_EM_WT))
    else $error("result valid outside emit");

endmodule

/* hw/rtl/spfe_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module spfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
